### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CPPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define CPPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/cppm_pkg.sv
package cppm_pkg;

    localparam int unsigned NS_PER_US = 1000;

    localparam int TICKS_W   = 24;
    localparam int PERIOD_W  = 20;
    localparam int KIND_W    = 2;
    localparam int CHAN_W    = 5;
    localparam int VALUE_W   = 8;
    localparam int CFG_IDX_W = 8;

    // interval products (ticks * ns per tick) are held saturated at this width
    localparam int NS_W = 26;
    localparam logic [NS_W-1:0] NS_CAP = '1;

    // microsecond limits moved into the product domain, upper limits exclusive
    localparam logic [NS_W-1:0] SEP_MIN_NS  = NS_W'(50 * NS_PER_US);
    localparam logic [NS_W-1:0] SEP_LIM_NS  = NS_W'((900 + 1) * NS_PER_US);
    localparam logic [NS_W-1:0] CHAN_MIN_NS = NS_W'(700 * NS_PER_US);
    localparam logic [NS_W-1:0] CHAN_LIM_NS = NS_W'((2400 + 1) * NS_PER_US);
    localparam logic [NS_W-1:0] SYNC_MIN_NS = NS_W'(3000 * NS_PER_US);
    localparam logic [NS_W-1:0] SYNC_LIM_NS = NS_W'((40000 + 1) * NS_PER_US);

    localparam int unsigned MIN_FRAME_CH = 3;

    // value = floor((ns + 5 us) / 10 us), done as a reciprocal multiply
    localparam int Q_W         = 22;
    localparam int unsigned ROUND_NS  = 5 * NS_PER_US;
    localparam int unsigned VALUE_DIV = 10 * NS_PER_US;
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(VALUE_DIV) - 64'd1) / 64'(VALUE_DIV));

    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR_LEVEL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD_NS = CFG_IDX_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_CHANNEL = 2'd0,
        KIND_FRAME   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef struct packed {
        logic sep_level;
        logic [PERIOD_W-1:0] period;
    } t_cfg;

    typedef struct packed {
        logic rec_start;
        logic rec_end;
        logic level;
        logic [TICKS_W-1:0] ticks;
        logic [NS_W-1:0] ns;
    } t_run;

    typedef struct packed {
        t_kind kind;
        logic [CHAN_W-1:0] chan;
        logic [CHAN_W-1:0] frame;
        logic [Q_W-1:0] q;
    } t_result;

endpackage

### hw/rtl/cppm_run_stage.sv
module cppm_run_stage (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_level,
    input  logic [cppm_pkg::TICKS_W-1:0] i_ticks,
    input  logic i_start,
    input  logic i_end,
    input  logic [cppm_pkg::PERIOD_W-1:0] i_period,
    input  logic i_ready,
    output logic o_ready,
    output logic o_valid,
    output cppm_pkg::t_run o_run
);
    import cppm_pkg::*;

    localparam int PROD_W = TICKS_W + PERIOD_W;

    logic [PROD_W-1:0] w_prod;
    t_run n_run;
    t_run r_run;
    logic r_valid;

    assign w_prod = PROD_W'(i_ticks) * PROD_W'(i_period);

    always_comb begin
        n_run.rec_start = i_start;
        n_run.rec_end   = i_end;
        n_run.level     = i_level;
        n_run.ticks     = i_ticks;
        n_run.ns        = (|w_prod[PROD_W-1:NS_W]) ? NS_CAP : w_prod[NS_W-1:0];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_run   = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_run <= n_run;
        end
    end

endmodule

### hw/rtl/cppm_frame_track.sv
module cppm_frame_track #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  cppm_pkg::t_run i_run,
    input  cppm_pkg::t_cfg i_cfg,
    input  logic i_period_wr,
    input  logic [cppm_pkg::PERIOD_W-1:0] i_period_data,
    input  logic i_ready,
    output logic o_ready,
    output logic o_valid,
    output cppm_pkg::t_result o_res
);
    import cppm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int CPROD_W = NS_W + PERIOD_W;

    logic [NS_W-1:0] r_elapsed_ticks, n_elapsed_ticks;
    logic [NS_W-1:0] r_elapsed_ns, n_elapsed_ns;
    logic r_have_sep, n_have_sep;
    logic r_frame_open, n_frame_open;
    logic [CNT_W-1:0] r_count, n_count;
    logic r_error, n_error;
    logic r_res_valid, n_res_valid;
    t_result r_res, n_res;

    logic w_fire;
    logic w_is_sep;
    logic w_width_ok;
    logic w_is_chan;
    logic w_is_sync;
    logic [NS_W:0] w_tick_sum;
    logic [NS_W:0] w_ns_sum;
    logic [CPROD_W-1:0] w_cfg_prod;

    assign o_ready = !r_res_valid || i_ready;
    assign o_valid = r_res_valid;
    assign o_res   = r_res;
    assign w_fire  = i_valid && o_ready;

    assign w_is_sep   = i_run.level == i_cfg.sep_level;
    assign w_width_ok = (i_run.ns >= SEP_MIN_NS) && (i_run.ns < SEP_LIM_NS);
    assign w_is_chan  = (r_elapsed_ns >= CHAN_MIN_NS) && (r_elapsed_ns < CHAN_LIM_NS);
    assign w_is_sync  = (r_elapsed_ns >= SYNC_MIN_NS) && (r_elapsed_ns < SYNC_LIM_NS);
    assign w_tick_sum = {1'b0, r_elapsed_ticks} + (NS_W+1)'(i_run.ticks);
    assign w_ns_sum   = {1'b0, r_elapsed_ns} + {1'b0, i_run.ns};

    // a new period rescales the interval already counted
    assign w_cfg_prod = CPROD_W'(r_elapsed_ticks) * CPROD_W'(i_period_data);

    always_comb begin
        n_elapsed_ticks = r_elapsed_ticks;
        n_elapsed_ns    = r_elapsed_ns;
        n_have_sep      = r_have_sep;
        n_frame_open    = r_frame_open;
        n_count         = r_count;
        n_error         = r_error;
        n_res_valid     = 1'b0;
        n_res           = '0;
        if (w_fire) begin
            priority if (i_run.rec_start) begin
                n_elapsed_ticks = '0;
                n_elapsed_ns    = '0;
                n_have_sep      = 1'b0;
                n_frame_open    = 1'b0;
                n_count         = '0;
                n_error         = 1'b0;
            end else if (i_run.rec_end || r_error) begin
                // run skipped
            end else if (!w_is_sep) begin
                n_elapsed_ticks = w_tick_sum[NS_W] ? NS_CAP : w_tick_sum[NS_W-1:0];
                n_elapsed_ns    = w_ns_sum[NS_W] ? NS_CAP : w_ns_sum[NS_W-1:0];
            end else if (!w_width_ok) begin
                n_error     = 1'b1;
                n_res_valid = 1'b1;
                n_res.kind  = KIND_ERROR;
            end else if (!r_have_sep) begin
                n_have_sep      = 1'b1;
                n_elapsed_ticks = NS_W'(i_run.ticks);
                n_elapsed_ns    = i_run.ns;
            end else begin
                n_elapsed_ticks = NS_W'(i_run.ticks);
                n_elapsed_ns    = i_run.ns;
                priority if (w_is_chan) begin
                    // channels before the first sync are dropped
                    if (r_frame_open) begin
                        if (r_count >= CNT_W'(MAX_CHANNELS)) begin
                            n_error     = 1'b1;
                            n_res_valid = 1'b1;
                            n_res.kind  = KIND_ERROR;
                        end else begin
                            n_count     = r_count + 1'b1;
                            n_res_valid = 1'b1;
                            n_res.kind  = KIND_CHANNEL;
                            n_res.chan  = CHAN_W'(n_count);
                            n_res.q     = Q_W'(r_elapsed_ns) + Q_W'(ROUND_NS);
                        end
                    end
                end else if (!w_is_sync) begin
                    n_error     = 1'b1;
                    n_res_valid = 1'b1;
                    n_res.kind  = KIND_ERROR;
                end else if (r_frame_open) begin
                    if (r_count < CNT_W'(MIN_FRAME_CH)) begin
                        n_error     = 1'b1;
                        n_res_valid = 1'b1;
                        n_res.kind  = KIND_ERROR;
                    end else begin
                        n_count     = '0;
                        n_res_valid = 1'b1;
                        n_res.kind  = KIND_FRAME;
                        n_res.frame = CHAN_W'(r_count);
                    end
                end else begin
                    n_frame_open = 1'b1;
                    n_count      = '0;
                end
            end
        end else if (i_period_wr) begin
            n_elapsed_ns = (|w_cfg_prod[CPROD_W-1:NS_W]) ? NS_CAP : w_cfg_prod[NS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed_ticks <= '0;
            r_elapsed_ns    <= '0;
            r_have_sep      <= 1'b0;
            r_frame_open    <= 1'b0;
            r_count         <= '0;
            r_error         <= 1'b0;
            r_res_valid     <= 1'b0;
        end else begin
            r_elapsed_ticks <= n_elapsed_ticks;
            r_elapsed_ns    <= n_elapsed_ns;
            r_have_sep      <= n_have_sep;
            r_frame_open    <= n_frame_open;
            r_count         <= n_count;
            r_error         <= n_error;
            if (o_ready) begin
                r_res_valid <= n_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res_valid) begin
            r_res <= n_res;
        end
    end

    `include "assert_macros.svh"

    `CPPM_ASSERT(a_count_limit, r_count <= CNT_W'(MAX_CHANNELS), "channel count above limit")
    `CPPM_ASSERT(a_open_has_sep, r_frame_open |-> r_have_sep, "frame open without separator")
    `CPPM_ASSERT(a_err_latches, (n_res_valid && n_res.kind == KIND_ERROR) |=> r_error, "error not latched")
    `CPPM_ASSERT(a_err_quiet, r_error |-> !n_res_valid, "result while error latched")
    `CPPM_ASSERT(a_chan_in_frame, (n_res_valid && n_res.kind == KIND_CHANNEL) |-> r_frame_open, "channel outside frame")

endmodule

### hw/rtl/cppm_out_stage.sv
module cppm_out_stage (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  cppm_pkg::t_result i_res,
    input  logic i_out_stall,
    output logic o_ready,
    output logic o_out_valid,
    output logic [cppm_pkg::KIND_W-1:0] o_kind,
    output logic [cppm_pkg::CHAN_W-1:0] o_channel_number,
    output logic [cppm_pkg::VALUE_W-1:0] o_value_10us,
    output logic [cppm_pkg::CHAN_W-1:0] o_frame_channels
);
    import cppm_pkg::*;

    localparam int VPROD_W = Q_W + RECIP_W;

    logic [VPROD_W-1:0] w_prod;
    logic [VALUE_W-1:0] w_value;
    logic r_valid;
    logic [KIND_W-1:0] r_kind;
    logic [CHAN_W-1:0] r_chan;
    logic [VALUE_W-1:0] r_value;
    logic [CHAN_W-1:0] r_frame;

    // q is zero for anything but a channel, so the value comes out zero there
    assign w_prod  = VPROD_W'(i_res.q) * VPROD_W'(RECIP);
    assign w_value = w_prod[RECIP_SHIFT +: VALUE_W];

    assign o_ready          = !r_valid || !i_out_stall;
    assign o_out_valid      = r_valid;
    assign o_kind           = r_kind;
    assign o_channel_number = r_chan;
    assign o_value_10us     = r_value;
    assign o_frame_channels = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind  <= i_res.kind;
            r_chan  <= i_res.chan;
            r_value <= w_value;
            r_frame <= i_res.frame;
        end
    end

    `include "assert_macros.svh"

    `CPPM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !r_valid, "output valid after reset")
    `CPPM_ASSERT(a_value_chan_only, (r_valid && r_kind != KIND_CHANNEL) |-> r_value == '0, "value on non-channel")

endmodule

### hw/rtl/cppm_frame_decoder.sv
// CPPM sum-signal decoder working on level runs. Each accepted transaction is one
// run (level, length in sample ticks, record start and end marks); a run yields at
// most one result: a channel with its 1-based number and value in 10 us steps, a
// closed frame with its channel count, or an error that holds until the next
// record start. One run is accepted per clock unless the input stalls; a result
// passes the tick-period multiply, the frame tracker and the rounding multiply,
// each ending in a register. The input stalls only when a result waits at the
// output and every stage behind it is full. No clearing pass after reset.
// Registers: index 0 separator level (reset 1), index 1 sample period in ns
// (reset 1000); write them only while no run is in flight.
module cppm_frame_decoder #(
    parameter int MAX_CHANNELS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_run_level,
    input  logic [cppm_pkg::TICKS_W-1:0] i_run_ticks,
    input  logic i_record_start,
    input  logic i_record_end,
    output logic o_out_valid,
    input  logic i_out_stall,
    output logic [cppm_pkg::KIND_W-1:0] o_kind,
    output logic [cppm_pkg::CHAN_W-1:0] o_channel_number,
    output logic [cppm_pkg::VALUE_W-1:0] o_value_10us,
    output logic [cppm_pkg::CHAN_W-1:0] o_frame_channels,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [cppm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cppm_pkg::PERIOD_W-1:0] i_cfg_data
);
    import cppm_pkg::*;

    t_cfg r_cfg;
    logic w_cfg_wr;
    logic w_period_wr;
    logic w_s1_ready, w_s1_valid;
    t_run w_s1_run;
    logic w_s2_ready, w_s2_valid;
    t_result w_s2_res;
    logic w_s3_ready;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_period_wr = w_cfg_wr && (i_cfg_index == REG_SAMPLE_PERIOD_NS);
    assign o_in_stall  = !w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sep_level <= 1'b1;
            r_cfg.period    <= PERIOD_W'(NS_PER_US);
        end else if (w_cfg_wr) begin
            priority if (i_cfg_index == REG_SEPARATOR_LEVEL) begin
                r_cfg.sep_level <= i_cfg_data[0];
            end else if (i_cfg_index == REG_SAMPLE_PERIOD_NS) begin
                r_cfg.period <= i_cfg_data;
            end
        end
    end

    cppm_run_stage u_run (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_level  (i_run_level),
        .i_ticks  (i_run_ticks),
        .i_start  (i_record_start),
        .i_end    (i_record_end),
        .i_period (r_cfg.period),
        .i_ready  (w_s2_ready),
        .o_ready  (w_s1_ready),
        .o_valid  (w_s1_valid),
        .o_run    (w_s1_run)
    );

    cppm_frame_track #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_s1_valid),
        .i_run         (w_s1_run),
        .i_cfg         (r_cfg),
        .i_period_wr   (w_period_wr),
        .i_period_data (i_cfg_data),
        .i_ready       (w_s3_ready),
        .o_ready       (w_s2_ready),
        .o_valid       (w_s2_valid),
        .o_res         (w_s2_res)
    );

    cppm_out_stage u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_s2_valid),
        .i_res            (w_s2_res),
        .i_out_stall      (i_out_stall),
        .o_ready          (w_s3_ready),
        .o_out_valid      (o_out_valid),
        .o_kind           (o_kind),
        .o_channel_number (o_channel_number),
        .o_value_10us     (o_value_10us),
        .o_frame_channels (o_frame_channels)
    );

endmodule
